// File: design/rpg_pkg.sv
`timescale 1ns / 1ps

package rpg_pkg;

  // Default sizes of the point table and of one stored coordinate.
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 14;

  // Fixed widths of the stream and configuration fields.
  localparam int INDEX_W  = 6;
  localparam int FIELD_W  = 14;
  localparam int COUNT_W  = 7;
  localparam int THRESH_W = 30;

  // Packed stream words, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  // Pair results per scan and the skip counter both stop at this value.
  localparam logic [INDEX_W-1:0] SAT_MAX = 6'h3F;

  localparam logic [COUNT_W-1:0]  POINT_COUNT_RST = 7'd0;
  localparam logic [THRESH_W-1:0] MAX_DIST_SQ_RST = 30'h2000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_MAX_DIST_SQ = 1'b1
  } cfg_reg_e;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic               is_pair;
    logic               last;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic [FIELD_W-1:0] first_row;
    logic [FIELD_W-1:0] first_col;
    logic [FIELD_W-1:0] second_row;
    logic [FIELD_W-1:0] second_col;
    logic [INDEX_W-1:0] skipped;
  } out_item_t;

endpackage

// File: design/rpg_ram.sv
`timescale 1ns / 1ps

module rpg_ram #(
  parameter int Width = 28,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/radius_pair_generator.sv
`timescale 1ns / 1ps

// A load is written at its own transaction edge. A scan of row i over N points visits
// every later point below N and then shows its closing result (it goes straight to closing
// when i >= N): each later point takes one point RAM read and two passes through the shared
// squaring multiplier, and a result held in the full output register stalls the sequence.
// Throughput: one transaction at a time; s_axis_tready is low until the closing result.
// Reset (rst_ni low, asynchronous) clears control state and registers, not the point table.
module radius_pair_generator
  import rpg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [THRESH_W-1:0]   cfg_data_i,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_index [5:0], coord_row [19:6], coord_col [33:20], zero [39:34]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op [0]
  input  logic                  s_axis_tuser,
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // first_index [5:0], second_index [11:6], first_row [25:12],
  // first_col [39:26], second_row [53:40], second_col [67:54],
  // skipped [73:68], zero [79:74]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // is_pair [0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int XW   = (AW > COUNT_W) ? AW : COUNT_W;
  localparam int WB   = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int PW   = 2 * COORD_BITS;
  localparam int DW   = PW + 1;
  localparam int CMPW = (DW > THRESH_W) ? DW : THRESH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOLD_I,
    S_FETCH_J,
    S_DIFF,
    S_SQ_ROW,
    S_SQ_COL,
    S_JUDGE,
    S_CLOSE
  } state_e;

  state_e                state_q;
  logic [COUNT_W-1:0]    point_count_q;
  logic [THRESH_W-1:0]   max_dist_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [COUNT_W-1:0]    count_q;
  logic [COUNT_W-1:0]    j_q;
  logic [INDEX_W-1:0]    pairs_q;
  logic [INDEX_W-1:0]    skip_q;
  logic [COORD_BITS-1:0] ri_q, ci_q, rj_q, cj_q;
  logic [COORD_BITS-1:0] dr_q, dc_q;
  logic [PW-1:0]         acc_q, sq_q;
  logic                  m_valid_q;
  out_item_t             out_q;

  // Input fields.
  logic [INDEX_W-1:0] in_index;
  logic [FIELD_W-1:0] in_row, in_col;
  op_e                in_op;
  logic               in_accept;

  assign in_index  = s_axis_tdata[INDEX_W-1:0];
  assign in_row    = s_axis_tdata[INDEX_W+FIELD_W-1:INDEX_W];
  assign in_col    = s_axis_tdata[INDEX_W+2*FIELD_W-1:INDEX_W+FIELD_W];
  assign in_op     = op_e'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Points at or above the configured count never take part in pairing.
  logic [COUNT_W-1:0] count_eff;
  assign count_eff = (32'(point_count_q) > MAX_POINTS) ? COUNT_W'(MAX_POINTS)
                                                       : point_count_q;

  // Point RAM: the write takes the incoming load, reads follow the sequencer.
  logic [WB-1:0]           row_wide, col_wide;
  logic [XW-1:0]           idx_wide, j_wide;
  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [COORD_BITS-1:0]   rd_row, rd_col;

  assign row_wide  = WB'(in_row);
  assign col_wide  = WB'(in_col);
  assign idx_wide  = XW'(in_index);
  assign j_wide    = XW'(j_q);
  assign ram_we    = in_accept && (in_op == OP_LOAD) && (32'(in_index) < MAX_POINTS);
  assign ram_addr  = (state_q == S_IDLE) ? idx_wide[AW-1:0] : j_wide[AW-1:0];
  assign ram_wdata = {col_wide[COORD_BITS-1:0], row_wide[COORD_BITS-1:0]};
  assign rd_row    = ram_rdata[COORD_BITS-1:0];
  assign rd_col    = ram_rdata[2*COORD_BITS-1:COORD_BITS];

  rpg_ram #(
    .Width (2 * COORD_BITS),
    .Depth (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // The one multiplier squares the row difference, then the column difference.
  logic [COORD_BITS-1:0] mul_op;
  logic [PW-1:0]         mul_res;
  assign mul_op  = (state_q == S_SQ_ROW) ? dr_q : dc_q;
  assign mul_res = PW'(mul_op) * PW'(mul_op);

  logic [DW-1:0] dist_sq;
  logic          in_reach;
  assign dist_sq  = {1'b0, acc_q} + {1'b0, sq_q};
  assign in_reach = CMPW'(dist_sq) <= CMPW'(max_dist_q);

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // A new result enters the output register on an emitted pair or on closing.
  logic out_load;
  assign out_load = out_free &&
                    (((state_q == S_JUDGE) && in_reach && (pairs_q != SAT_MAX)) ||
                     (state_q == S_CLOSE));

  // Stored coordinates widened so that they can be cut to the field width.
  logic [WB-1:0] ri_wide, ci_wide, rj_wide, cj_wide;
  assign ri_wide = WB'(ri_q);
  assign ci_wide = WB'(ci_q);
  assign rj_wide = WB'(rj_q);
  assign cj_wide = WB'(cj_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= POINT_COUNT_RST;
      max_dist_q    <= MAX_DIST_SQ_RST;
      idx_q         <= '0;
      count_q       <= '0;
      j_q           <= '0;
      pairs_q       <= '0;
      skip_q        <= '0;
      ri_q          <= '0;
      ci_q          <= '0;
      rj_q          <= '0;
      cj_q          <= '0;
      dr_q          <= '0;
      dc_q          <= '0;
      acc_q         <= '0;
      sq_q          <= '0;
      m_valid_q     <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_POINT_COUNT: point_count_q <= cfg_data_i[COUNT_W-1:0];
          CFG_MAX_DIST_SQ: max_dist_q    <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept && (in_op == OP_SCAN)) begin
            idx_q   <= in_index;
            count_q <= count_eff;
            pairs_q <= '0;
            skip_q  <= '0;
            // The RAM read of point i was issued in this same cycle.
            state_q <= ({1'b0, in_index} < count_eff) ? S_HOLD_I : S_CLOSE;
          end
        end
        S_HOLD_I: begin
          ri_q    <= rd_row;
          ci_q    <= rd_col;
          j_q     <= {1'b0, idx_q} + COUNT_W'(1);
          state_q <= S_FETCH_J;
        end
        S_FETCH_J: begin
          state_q <= (j_q < count_q) ? S_DIFF : S_CLOSE;
        end
        S_DIFF: begin
          rj_q    <= rd_row;
          cj_q    <= rd_col;
          dr_q    <= (ri_q >= rd_row) ? ri_q - rd_row : rd_row - ri_q;
          dc_q    <= (ci_q >= rd_col) ? ci_q - rd_col : rd_col - ci_q;
          state_q <= S_SQ_ROW;
        end
        S_SQ_ROW: begin
          acc_q   <= mul_res;
          state_q <= S_SQ_COL;
        end
        S_SQ_COL: begin
          sq_q    <= mul_res;
          state_q <= S_JUDGE;
        end
        S_JUDGE: begin
          if (in_reach && (pairs_q != SAT_MAX)) begin
            if (out_free) begin
              out_q.is_pair      <= 1'b1;
              out_q.last         <= 1'b0;
              out_q.first_index  <= idx_q;
              out_q.second_index <= j_q[INDEX_W-1:0];
              out_q.first_row    <= ri_wide[FIELD_W-1:0];
              out_q.first_col    <= ci_wide[FIELD_W-1:0];
              out_q.second_row   <= rj_wide[FIELD_W-1:0];
              out_q.second_col   <= cj_wide[FIELD_W-1:0];
              out_q.skipped      <= '0;
              pairs_q            <= pairs_q + INDEX_W'(1);
              j_q                <= j_q + COUNT_W'(1);
              state_q            <= S_FETCH_J;
            end
          end else begin
            // Pairs past the result cap are dropped without being counted.
            if (!in_reach && (skip_q != SAT_MAX)) begin
              skip_q <= skip_q + INDEX_W'(1);
            end
            j_q     <= j_q + COUNT_W'(1);
            state_q <= S_FETCH_J;
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            out_q.is_pair      <= 1'b0;
            out_q.last         <= 1'b1;
            out_q.first_index  <= idx_q;
            out_q.second_index <= '0;
            out_q.first_row    <= '0;
            out_q.first_col    <= '0;
            out_q.second_row   <= '0;
            out_q.second_col   <= '0;
            out_q.skipped      <= skip_q;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.is_pair;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'b0, out_q.skipped, out_q.second_col, out_q.second_row,
                          out_q.first_col, out_q.first_row, out_q.second_index,
                          out_q.first_index};

  // Every later point visited so far is either emitted, dropped or skipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH_J) |->
      ({2'b0, skip_q} + {2'b0, pairs_q}) <= ({1'b0, j_q} - {2'b0, idx_q} - 8'd1))
    else $error("pair and skip counts exceed the points visited");

  // A point read for comparison always lies after point i and below the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |-> (j_q > {1'b0, idx_q}) && (j_q < count_q))
    else $error("scan visited a point outside its row");

  // A scan transaction either fetches point i or closes at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_op == OP_SCAN)) |=> (state_q == S_HOLD_I) || (state_q == S_CLOSE))
    else $error("scan did not start");

  // Leaving the closing state always leaves a closing result in the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE && out_free) |=> m_valid_q && out_q.last && !out_q.is_pair)
    else $error("closing result was not issued");

endmodule
